// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SLXD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slxd assertion failed");

// next-cycle implication, disabled while reset is low
`define SLXD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slxd assertion failed");

`endif

// ===== hdl/slxd_pkg.sv =====
`default_nettype none

package slxd_pkg;

    localparam int unsigned SLXD_BUFFER_DEPTH = 64;

    // wide enough for an 8-bit length plus two
    localparam int unsigned SLXD_LEN_W = 9;

    localparam logic [7:0] SYNC_HEAD     = 8'hAA;
    localparam logic [7:0] SYNC_TAIL     = 8'h55;
    localparam logic [7:0] TYPE_SENSOR_0 = 8'h28;
    localparam logic [7:0] TYPE_SENSOR_1 = 8'h10;
    localparam logic [7:0] TYPE_IMU_0    = 8'h21;
    localparam logic [7:0] TYPE_IMU_1    = 8'h11;
    localparam logic [7:0] TAG_POWER     = 8'h01;
    localparam logic [7:0] TAG_IR        = 8'h03;
    localparam logic [7:0] TAG_CURRENT   = 8'h05;
    localparam logic [7:0] TAG_ULTRA     = 8'h03;
    localparam logic [7:0] TAG_ENCODER   = 8'h05;

    // header bytes the front keeps a copy of, by slot
    localparam int unsigned SLXD_NTAG  = 7;
    localparam int unsigned TI_TYPE0   = 0;
    localparam int unsigned TI_TYPE1   = 1;
    localparam int unsigned TI_POWER   = 2;
    localparam int unsigned TI_IR      = 3;
    localparam int unsigned TI_CURRENT = 4;
    localparam int unsigned TI_ULTRA   = 5;
    localparam int unsigned TI_ENCODER = 6;
    localparam int unsigned SLXD_TAG_POS [SLXD_NTAG] = '{0, 1, 2, 5, 12, 23, 30};

    // quantity codes
    localparam int unsigned SLXD_QW   = 5;
    localparam int unsigned SLXD_NQ   = 27;
    localparam logic [SLXD_QW-1:0] Q_STATUS    = 5'd0;
    localparam logic [SLXD_QW-1:0] Q_POWER     = 5'd1;
    localparam logic [SLXD_QW-1:0] Q_IR_FIRST  = 5'd2;
    localparam logic [SLXD_QW-1:0] Q_IR_LAST   = 5'd4;
    localparam logic [SLXD_QW-1:0] Q_CUR_FIRST = 5'd5;
    localparam logic [SLXD_QW-1:0] Q_CUR_LAST  = 5'd8;
    localparam logic [SLXD_QW-1:0] Q_US_FIRST  = 5'd9;
    localparam logic [SLXD_QW-1:0] Q_US_LAST   = 5'd11;
    localparam logic [SLXD_QW-1:0] Q_ENC_FIRST = 5'd12;
    localparam logic [SLXD_QW-1:0] Q_ENC_LAST  = 5'd15;
    localparam logic [SLXD_QW-1:0] Q_IMU_FIRST = 5'd16;
    localparam logic [SLXD_QW-1:0] Q_IMU_LAST  = 5'd24;
    localparam logic [SLXD_QW-1:0] Q_TEMP      = 5'd25;
    localparam logic [SLXD_QW-1:0] Q_TIME      = 5'd26;

    typedef enum logic [1:0] {
        ST_OK,
        ST_CHECKSUM,
        ST_UNKNOWN,
        ST_OVERFLOW
    } t_status;

    typedef logic [SLXD_NQ-1:0] t_qmask;

    // one run of result items: status code plus the set of quantities to emit
    typedef struct packed {
        logic    uses_store;
        t_status status;
        t_qmask  mask;
    } t_job;

    function automatic t_job slxd_overflow_job();
        t_job j;
        j.uses_store     = 1'b0;
        j.status         = ST_OVERFLOW;
        j.mask           = '0;
        j.mask[Q_STATUS] = 1'b1;
        return j;
    endfunction

    function automatic t_job slxd_frame_job(
        input logic [7:0] t0,
        input logic [7:0] t1,
        input logic [7:0] tp,
        input logic [7:0] ti,
        input logic [7:0] tc,
        input logic [7:0] tu,
        input logic [7:0] te,
        input logic       sum_ok
    );
        t_job j;
        j.status         = ST_OK;
        j.mask           = '0;
        j.mask[Q_STATUS] = 1'b1;
        if (!sum_ok) begin
            j.status = ST_CHECKSUM;
        end else if (t0 == TYPE_SENSOR_0 && t1 == TYPE_SENSOR_1) begin
            if (tp == TAG_POWER) begin
                j.mask[Q_POWER] = 1'b1;
            end
            if (ti == TAG_IR) begin
                j.mask[Q_IR_LAST:Q_IR_FIRST] = '1;
            end
            if (tc == TAG_CURRENT) begin
                j.mask[Q_CUR_LAST:Q_CUR_FIRST] = '1;
            end
            if (tu == TAG_ULTRA) begin
                j.mask[Q_US_LAST:Q_US_FIRST] = '1;
            end
            if (te == TAG_ENCODER) begin
                j.mask[Q_ENC_LAST:Q_ENC_FIRST] = '1;
            end
        end else if (t0 == TYPE_IMU_0 && t1 == TYPE_IMU_1) begin
            j.mask[Q_TIME:Q_IMU_FIRST] = '1;
        end else begin
            j.status = ST_UNKNOWN;
        end
        j.uses_store = |j.mask[SLXD_NQ-1:1];
        return j;
    endfunction

    // lowest quantity still to be emitted
    function automatic logic [SLXD_QW-1:0] slxd_first(input t_qmask m);
        logic [SLXD_QW-1:0] q;
        q = Q_STATUS;
        for (int i = SLXD_NQ - 1; i >= 0; i--) begin
            if (m[i]) begin
                q = SLXD_QW'(i);
            end
        end
        return q;
    endfunction

    // store position of the low byte of a quantity's value
    function automatic logic [5:0] slxd_pos(input logic [SLXD_QW-1:0] q);
        logic [5:0] dbl;
        logic [5:0] p;
        dbl = {q, 1'b0};
        unique case (q) inside
            Q_POWER:                   p = dbl + 6'd1;
            [Q_IR_FIRST:Q_IR_LAST]:    p = dbl + 6'd2;
            [Q_CUR_FIRST:Q_CUR_LAST]:  p = dbl + 6'd3;
            [Q_US_FIRST:Q_US_LAST]:    p = dbl + 6'd6;
            [Q_ENC_FIRST:Q_ENC_LAST]:  p = dbl + 6'd7;
            [Q_IMU_FIRST:Q_IMU_LAST]:  p = dbl - 6'd30;
            Q_TEMP:                    p = 6'd20;
            Q_TIME:                    p = 6'd24;
            default:                   p = 6'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/slxd_store.sv =====
`default_nettype none

module slxd_store
    import slxd_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = SLXD_BUFFER_DEPTH,
    localparam int unsigned AW = $clog2(BUFFER_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_lo,
    output logic      [7:0]    o_rd_hi
);

    logic [7:0] r_mem [BUFFER_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two adjacent bytes per read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_lo <= r_mem[i_rd_addr];
            o_rd_hi <= r_mem[i_rd_addr + AW'(1)];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slxd_front.sv =====
`default_nettype none

module slxd_front
    import slxd_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = SLXD_BUFFER_DEPTH,
    localparam int unsigned AW = $clog2(BUFFER_DEPTH),
    localparam int unsigned IW = $clog2(BUFFER_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_full,
    input  wire logic          i_job_full,
    output logic               o_job_push,
    output t_job               o_job,
    input  wire logic          i_store_done,
    output logic               o_wr_en,
    output logic      [AW-1:0] o_wr_addr,
    output logic      [7:0]    o_wr_data
);

    logic          r_head;
    logic          r_in_frame;
    logic [IW-1:0] r_widx;
    logic [7:0]    r_xor;
    logic          r_pend;
    logic [7:0]    r_tag [SLXD_NTAG];

    logic                  accept;
    logic                  n_head;
    logic                  do_store;
    logic                  do_sync;
    logic                  check_end;
    logic                  ovf;
    logic                  complete;
    logic [7:0]            eff_tag [SLXD_NTAG];
    logic [SLXD_LEN_W-1:0] next_cnt;
    logic [SLXD_LEN_W-1:0] end_cnt;
    t_job                  frame_job;

    assign o_full = i_job_full | r_pend;
    assign accept = i_push & ~o_full;

    always_comb begin
        n_head    = r_head;
        do_store  = 1'b0;
        do_sync   = 1'b0;
        check_end = 1'b0;
        if (i_rx_byte == SYNC_HEAD) begin
            n_head   = 1'b1;
            do_store = r_in_frame;
        end else if (i_rx_byte == SYNC_TAIL) begin
            if (r_head) begin
                n_head  = 1'b0;
                do_sync = 1'b1;
            end else begin
                do_store = r_in_frame;
            end
        end else begin
            n_head    = 1'b0;
            do_store  = r_in_frame;
            check_end = 1'b1;
        end
    end

    assign ovf = do_store & (r_widx >= IW'(BUFFER_DEPTH));

    // header bytes as they will read once this byte is stored
    always_comb begin
        for (int k = 0; k < SLXD_NTAG; k++) begin
            eff_tag[k] = (do_store && r_widx == IW'(SLXD_TAG_POS[k])) ? i_rx_byte : r_tag[k];
        end
    end

    assign next_cnt = SLXD_LEN_W'(r_widx) + SLXD_LEN_W'(1);
    assign end_cnt  = {1'b0, eff_tag[TI_TYPE0]} + SLXD_LEN_W'(2);
    assign complete = do_store & ~ovf & check_end & (next_cnt == end_cnt);

    assign frame_job = slxd_frame_job(eff_tag[TI_TYPE0], eff_tag[TI_TYPE1], eff_tag[TI_POWER],
                                      eff_tag[TI_IR], eff_tag[TI_CURRENT], eff_tag[TI_ULTRA],
                                      eff_tag[TI_ENCODER], (r_xor ^ i_rx_byte) == 8'h00);

    assign o_job_push = accept & (ovf | complete);
    assign o_job      = ovf ? slxd_overflow_job() : frame_job;

    assign o_wr_en   = accept & do_store & ~ovf;
    assign o_wr_addr = r_widx[AW-1:0];
    assign o_wr_data = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= 1'b0;
            r_in_frame <= 1'b0;
            r_widx     <= '0;
            r_xor      <= 8'h00;
            r_pend     <= 1'b0;
        end else begin
            if (accept) begin
                r_head <= n_head;
                if (do_sync) begin
                    r_in_frame <= 1'b1;
                    r_widx     <= '0;
                    r_xor      <= 8'h00;
                end
                if (o_wr_en) begin
                    r_widx <= r_widx + IW'(1);
                    r_xor  <= r_xor ^ i_rx_byte;
                end
                if (ovf || complete) begin
                    r_in_frame <= 1'b0;
                end
            end
            // hold input off while the back end still reads the store
            if (accept && complete && frame_job.uses_store) begin
                r_pend <= 1'b1;
            end else if (i_store_done) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLXD_NTAG; k++) begin
            if (o_wr_en && r_widx == IW'(SLXD_TAG_POS[k])) begin
                r_tag[k] <= i_rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slxd_job_fifo.sv =====
`default_nettype none

module slxd_job_fifo
    import slxd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    t_job                r_slot [DEPTH];
    logic [PW-1:0]       r_wptr;
    logic [PW-1:0]       r_rptr;
    logic [CW-1:0]       r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_slot[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slxd_back.sv =====
`default_nettype none

module slxd_back
    import slxd_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = SLXD_BUFFER_DEPTH,
    localparam int unsigned AW = $clog2(BUFFER_DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_empty,
    input  wire t_job               i_job,
    output logic                    o_job_pop,
    output logic                    o_rd_en,
    output logic      [AW-1:0]      o_rd_addr,
    input  wire logic [7:0]         i_rd_lo,
    input  wire logic [7:0]         i_rd_hi,
    output logic                    o_store_done,
    output logic                    o_valid,
    input  wire logic               i_pop,
    output logic      [SLXD_QW-1:0] o_quantity,
    output logic      [31:0]        o_value,
    output logic                    o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_LO,
        S_HI
    } t_state;

    t_state  r_state;
    t_qmask  r_mask;
    t_status r_status;
    logic    r_uses;
    logic [15:0] r_lo;

    logic [SLXD_QW-1:0] q;
    logic [5:0]         pos;
    logic               wide;
    logic               out_free;
    logic               emit;
    t_qmask             rest;
    logic               rest_empty;
    logic [31:0]        value;

    assign q        = slxd_first(r_mask);
    assign pos      = slxd_pos(q);
    assign wide     = (q == Q_TEMP) || (q == Q_TIME);
    assign out_free = ~o_valid | i_pop;

    always_comb begin
        rest    = r_mask;
        rest[q] = 1'b0;
    end
    assign rest_empty = ~|rest;

    always_comb begin
        emit  = 1'b0;
        value = {16'h0000, i_rd_hi, i_rd_lo};
        unique case (r_state)
            S_IDLE: emit = 1'b0;
            S_STEP: begin
                emit  = out_free && q == Q_STATUS;
                value = 32'(r_status);
            end
            S_LO:   emit = out_free && !wide;
            S_HI: begin
                emit  = out_free;
                value = {i_rd_hi, i_rd_lo, r_lo};
            end
            default: emit = 1'b0;
        endcase
    end

    assign o_job_pop    = (r_state == S_IDLE) & ~i_job_empty;
    assign o_rd_en      = (r_state == S_STEP && q != Q_STATUS) || (r_state == S_LO && wide);
    assign o_rd_addr    = (r_state == S_LO) ? AW'(pos + 6'd2) : AW'(pos);
    assign o_store_done = emit & rest_empty & r_uses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (emit) begin
                o_valid    <= 1'b1;
                o_quantity <= q;
                o_value    <= value;
                o_last     <= rest_empty;
                r_mask     <= rest;
            end else if (i_pop) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_mask   <= i_job.mask;
                        r_status <= i_job.status;
                        r_uses   <= i_job.uses_store;
                        r_state  <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (q != Q_STATUS) begin
                        r_state <= S_LO;
                    end else if (emit) begin
                        r_state <= rest_empty ? S_IDLE : S_STEP;
                    end
                end
                S_LO: begin
                    if (wide) begin
                        r_lo    <= {i_rd_hi, i_rd_lo};
                        r_state <= S_HI;
                    end else if (emit) begin
                        r_state <= rest_empty ? S_IDLE : S_STEP;
                    end
                end
                S_HI: begin
                    if (emit) begin
                        r_state <= rest_empty ? S_IDLE : S_STEP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sync_length_xor_frame_decoder_core.sv =====
`default_nettype none

// Serial frame deframer with xor checksum. Bytes go in through push/full, one per
// transfer; 0xAA then 0x55 opens a frame, the first stored byte is the length L and the
// frame closes on a byte other than 0xAA/0x55 that makes L+2 stored bytes. Results come
// out through empty/pop: a status item (0 ok, 1 checksum error, 2 unknown type,
// 3 overflow) then the little-endian value of every present group, last set on the
// final one. A byte is taken every cycle while no frame read-out is pending and the
// two-entry job queue has room. Once a frame with groups completes, full stays high
// until its last item has been loaded into the output register. The read-out walks the
// store through one two-byte read port: it takes the run from the queue, emits the status
// item, reads each 16-bit value and emits it, reads each 32-bit value as two halves and
// emits it, and each emit waits while the output register is held. Overflow and error
// status items need no store access; they hold the input only while two runs already
// wait in the job queue behind a stalled output.

module sync_length_xor_frame_decoder_core
    import slxd_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = SLXD_BUFFER_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte input
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         i_rx_byte,
    // result output
    output logic                    empty,
    input  wire logic               pop,
    output logic      [SLXD_QW-1:0] o_quantity,
    output logic      [31:0]        o_value,
    output logic                    o_last
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    // job handoff between front and back
    logic job_push;
    t_job job_in;
    logic job_full;
    logic job_pop;
    t_job job_out;
    logic job_empty;

    // store ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_lo;
    logic [7:0]    rd_hi;

    logic store_done;
    logic out_valid;

    // front: sync detection, frame store writes, checksum and header classification
    slxd_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_rx_byte    (i_rx_byte),
        .o_full       (full),
        .i_job_full   (job_full),
        .o_job_push   (job_push),
        .o_job        (job_in),
        .i_store_done (store_done),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    // short queue of result runs so front and back stall on their own
    slxd_job_fifo u_jobs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    // frame bytes, one write port and one two-byte read port
    slxd_store #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_lo   (rd_lo),
        .o_rd_hi   (rd_hi)
    );

    // back: walks each run's quantity set and fills the output register
    slxd_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (job_empty),
        .i_job        (job_out),
        .o_job_pop    (job_pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_lo      (rd_lo),
        .i_rd_hi      (rd_hi),
        .o_store_done (store_done),
        .o_valid      (out_valid),
        .i_pop        (pop),
        .o_quantity   (o_quantity),
        .o_value      (o_value),
        .o_last       (o_last)
    );

    // the output register holds one result until its transfer
    assign empty = ~out_valid;

endmodule

`default_nettype wire

// ===== hdl/slxd_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module slxd_checker
    import slxd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               pop,
    input wire logic               empty,
    input wire logic [SLXD_QW-1:0] o_quantity,
    input wire logic [31:0]        o_value,
    input wire logic               o_last
);

    // a waiting result holds until its transfer
    `SLXD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_quantity) && $stable(o_value) && $stable(o_last))

    `SLXD_ASSERT_NOW(a_qty_range, i_clk, i_rst_n, !empty, o_quantity <= Q_TIME)

    `SLXD_ASSERT_NOW(a_status_code, i_clk, i_rst_n, !empty && o_quantity == Q_STATUS, o_value <= 32'd3)

    // only temperature and time count carry four bytes
    `SLXD_ASSERT_NOW(a_short_value, i_clk, i_rst_n, !empty && o_quantity != Q_STATUS && o_quantity < Q_TEMP, o_value[31:16] == 16'h0000)

endmodule

bind sync_length_xor_frame_decoder_core slxd_checker u_slxd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .pop        (pop),
    .empty      (empty),
    .o_quantity (o_quantity),
    .o_value    (o_value),
    .o_last     (o_last)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import slxd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned PHASE_BYTES  = 30;
    localparam int unsigned DRAIN_CYCLES = 64;

    // frame body lengths, from the length byte up to but not including the checksum byte
    localparam int unsigned SENSOR_BODY = 41;
    localparam int unsigned IMU_BODY    = 34;

    // tag positions inside a sensor frame
    localparam int unsigned POS_POWER   = 2;
    localparam int unsigned POS_IR      = 5;
    localparam int unsigned POS_CURRENT = 12;
    localparam int unsigned POS_ULTRA   = 23;
    localparam int unsigned POS_ENCODER = 30;

    // how frame payload bytes are filled
    localparam int FILL_ZERO = 0;
    localparam int FILL_ONES = 1;
    localparam int FILL_RAND = 2;

    typedef struct {
        logic [SLXD_QW-1:0] quantity;
        logic [31:0]        value;
        logic               is_last;
    } t_decoded_item;

    // byte-level deframer model plus the queue of items it still owes
    class frame_scoreboard;
        bit                 head_seen;
        bit                 in_frame;
        int unsigned        wr_idx;
        logic [7:0]         store [SLXD_BUFFER_DEPTH];
        logic [7:0]         run_xor;
        t_decoded_item      staged[$];
        t_decoded_item      pending[$];
        int unsigned        fails;

        function new();
            head_seen = 1'b0;
            in_frame  = 1'b0;
            wr_idx    = 0;
            run_xor   = 8'h00;
            fails     = 0;
            foreach (store[i]) store[i] = 8'h00;
        endfunction

        function bit put_byte(input logic [7:0] b);
            if (wr_idx >= SLXD_BUFFER_DEPTH) begin
                return 1'b0;
            end
            store[wr_idx] = b;
            wr_idx++;
            run_xor ^= b;
            return 1'b1;
        endfunction

        function logic [31:0] le16(input int unsigned p);
            return {16'h0000, store[(p + 1) % SLXD_BUFFER_DEPTH], store[p % SLXD_BUFFER_DEPTH]};
        endfunction

        function logic [31:0] le32(input int unsigned p);
            logic [31:0] lo;
            logic [31:0] hi;
            lo = le16(p);
            hi = le16(p + 2);
            return {hi[15:0], lo[15:0]};
        endfunction

        function void stage(input int unsigned q, input logic [31:0] v);
            t_decoded_item it;
            it.quantity = SLXD_QW'(q);
            it.value    = v;
            it.is_last  = 1'b0;
            staged.push_back(it);
        endfunction

        function void decode_frame();
            if (run_xor != 8'h00) begin
                stage(Q_STATUS, 32'(ST_CHECKSUM));
            end else if (store[0] == TYPE_SENSOR_0 && store[1] == TYPE_SENSOR_1) begin
                stage(Q_STATUS, 32'(ST_OK));
                if (store[POS_POWER] == TAG_POWER) begin
                    stage(Q_POWER, le16(3));
                end
                if (store[POS_IR] == TAG_IR) begin
                    for (int k = 0; k < 3; k++) stage(Q_IR_FIRST + k, le16(6 + 2 * k));
                end
                if (store[POS_CURRENT] == TAG_CURRENT) begin
                    for (int k = 0; k < 4; k++) stage(Q_CUR_FIRST + k, le16(13 + 2 * k));
                end
                if (store[POS_ULTRA] == TAG_ULTRA) begin
                    for (int k = 0; k < 3; k++) stage(Q_US_FIRST + k, le16(24 + 2 * k));
                end
                if (store[POS_ENCODER] == TAG_ENCODER) begin
                    for (int k = 0; k < 4; k++) stage(Q_ENC_FIRST + k, le16(31 + 2 * k));
                end
            end else if (store[0] == TYPE_IMU_0 && store[1] == TYPE_IMU_1) begin
                stage(Q_STATUS, 32'(ST_OK));
                for (int k = 0; k < 9; k++) stage(Q_IMU_FIRST + k, le16(2 + 2 * k));
                stage(Q_TEMP, le32(20));
                stage(Q_TIME, le32(24));
            end else begin
                stage(Q_STATUS, 32'(ST_UNKNOWN));
            end
        endfunction

        // one accepted byte: advance the model and queue whatever it emits
        function void note_byte(input logic [7:0] b);
            bit ovf;
            ovf = 1'b0;
            staged.delete();
            if (b == SYNC_HEAD) begin
                head_seen = 1'b1;
                if (in_frame) ovf = !put_byte(b);
            end else if (b == SYNC_TAIL) begin
                if (head_seen) begin
                    head_seen = 1'b0;
                    in_frame  = 1'b1;
                    wr_idx    = 0;
                    run_xor   = 8'h00;
                end else if (in_frame) begin
                    ovf = !put_byte(b);
                end
            end else begin
                head_seen = 1'b0;
                if (in_frame) begin
                    if (!put_byte(b)) begin
                        ovf = 1'b1;
                    end else if (wr_idx == int'(store[0]) + 2) begin
                        in_frame = 1'b0;
                        decode_frame();
                    end
                end
            end
            if (ovf) begin
                in_frame = 1'b0;
                stage(Q_STATUS, 32'(ST_OVERFLOW));
            end
            if (staged.size() > 0) begin
                staged[staged.size() - 1].is_last = 1'b1;
            end
            foreach (staged[i]) pending.push_back(staged[i]);
        endfunction

        function void check_result(input logic [SLXD_QW-1:0] q, input logic [31:0] v,
                                   input logic l);
            t_decoded_item exp_item;
            if (pending.size() == 0) begin
                $error("unexpected result: quantity %0d value %h last %b", q, v, l);
                fails++;
                return;
            end
            exp_item = pending.pop_front();
            if (q !== exp_item.quantity) begin
                $error("quantity: expected %0d, got %0d", exp_item.quantity, q);
                fails++;
            end
            if (v !== exp_item.value) begin
                $error("value: expected %h, got %h", exp_item.value, v);
                fails++;
            end
            if (l !== exp_item.is_last) begin
                $error("last: expected %b, got %b", exp_item.is_last, l);
                fails++;
            end
        endfunction

        function void close_out();
            if (pending.size() != 0) begin
                $error("%0d result items never arrived", pending.size());
                fails++;
            end
        endfunction
    endclass

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // dut signals, the driven inputs known from time zero
    logic               push      = 1'b0;
    logic               full;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               empty;
    logic               pop       = 1'b0;
    logic [SLXD_QW-1:0] o_quantity;
    logic [31:0]        o_value;
    logic               o_last;

    sync_length_xor_frame_decoder_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_rx_byte  (i_rx_byte),
        .empty      (empty),
        .pop        (pop),
        .o_quantity (o_quantity),
        .o_value    (o_value),
        .o_last     (o_last)
    );

    frame_scoreboard sb;

    // idle rates in percent, changed from phase to phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // watchdog
    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sync_length_xor_frame_decoder_core");
            $finish;
        end
    end

    // result side: check on a completed transfer, then pick the next pop
    // the values read here are the ones held before this edge, so no race
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_quantity, o_value, o_last);
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // bytes waiting to be sent, and the frame body under construction
    logic [7:0] tx[$];
    logic [7:0] body[$];

    function automatic logic [7:0] fill_byte(input int mode);
        case (mode)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    // sensor body: type bytes, each group tag present with tag_pct chance
    function automatic void make_sensor(input int unsigned tag_pct, input int mode);
        logic [7:0] b;
        body.delete();
        for (int i = 0; i < SENSOR_BODY; i++) begin
            b = fill_byte(mode);
            if (i == 0) b = TYPE_SENSOR_0;
            if (i == 1) b = TYPE_SENSOR_1;
            if ($urandom_range(99) < tag_pct) begin
                if (i == POS_POWER)   b = TAG_POWER;
                if (i == POS_IR)      b = TAG_IR;
                if (i == POS_CURRENT) b = TAG_CURRENT;
                if (i == POS_ULTRA)   b = TAG_ULTRA;
                if (i == POS_ENCODER) b = TAG_ENCODER;
            end
            body.push_back(b);
        end
    endfunction

    function automatic void make_imu(input int mode);
        body.delete();
        body.push_back(TYPE_IMU_0);
        body.push_back(TYPE_IMU_1);
        for (int i = 2; i < IMU_BODY; i++) body.push_back(fill_byte(mode));
    endfunction

    // short frame of random length, always of unknown type
    function automatic void make_short();
        logic [7:0] len;
        len = 8'($urandom_range(12));
        body.delete();
        body.push_back(len);
        for (int i = 0; i < len; i++) body.push_back(fill_byte(FILL_RAND));
    endfunction

    // sync, body and the closing checksum byte, optionally corrupted
    function automatic void seal_frame(input bit good_sum);
        logic [7:0] x;
        x = 8'h00;
        foreach (body[i]) x ^= body[i];
        if (!good_sum) x ^= 8'($urandom_range(1, 255));
        tx.push_back(SYNC_HEAD);
        tx.push_back(SYNC_TAIL);
        foreach (body[i]) tx.push_back(body[i]);
        tx.push_back(x);
    endfunction

    // one byte transfer; push stays high across back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        sb.note_byte(b);
    endtask

    task automatic send_all();
        while (tx.size() > 0) send_byte(tx.pop_front());
    endtask

    int unsigned counted;
    int unsigned pick;
    int unsigned keep;
    int unsigned sender_pct [4] = '{0, 77, 0, 31};
    int unsigned recv_pct   [4] = '{0, 0, 77, 31};

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        // bytes outside a frame, including a tail byte with no head before it
        tx = {8'h00, 8'hFF, SYNC_TAIL, 8'h12};
        // zero-length frame, good sum but unknown type
        tx = {tx, SYNC_HEAD, SYNC_TAIL, 8'h00, 8'h00};
        // zero-length frame with a bad sum
        tx = {tx, SYNC_HEAD, SYNC_TAIL, 8'h00, 8'h01};
        // head byte at the closing position, then a resync inside the frame
        tx = {tx, SYNC_HEAD, SYNC_TAIL, 8'h00, SYNC_HEAD, SYNC_TAIL, 8'h01, 8'h01, 8'h00};
        // tail byte at the closing position, frame runs on until the next sync
        tx = {tx, SYNC_HEAD, SYNC_TAIL, 8'h00, SYNC_TAIL, 8'h07};
        send_all();
        // sensor frame with no group present
        make_sensor(0, FILL_ZERO);
        seal_frame(1'b1);
        // full sensor frames at both value extremes, then a bad sum
        make_sensor(100, FILL_ONES);
        seal_frame(1'b1);
        make_sensor(100, FILL_ZERO);
        seal_frame(1'b1);
        make_sensor(100, FILL_RAND);
        seal_frame(1'b0);
        // imu frames at both value extremes
        make_imu(FILL_ONES);
        seal_frame(1'b1);
        make_imu(FILL_ZERO);
        seal_frame(1'b1);
        send_all();
        // overflow: a length that is never reached, store runs full
        tx = {SYNC_HEAD, SYNC_TAIL, 8'hFF};
        for (int i = 0; i < SLXD_BUFFER_DEPTH; i++) tx.push_back(8'h01);
        send_all();

        // random part, one phase per idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = sender_pct[ph];
            recv_stall_pct = recv_pct[ph];
            counted = 0;
            while (counted < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    make_sensor(70, FILL_RAND);
                    seal_frame($urandom_range(99) >= 15);
                end else if (pick < 55) begin
                    make_imu(FILL_RAND);
                    seal_frame($urandom_range(99) >= 15);
                end else if (pick < 72) begin
                    make_short();
                    seal_frame($urandom_range(99) >= 40);
                end else if (pick < 82) begin
                    // truncated frame, cut off by whatever sync comes next
                    make_sensor(70, FILL_RAND);
                    keep = $urandom_range(1, 20);
                    tx = {SYNC_HEAD, SYNC_TAIL};
                    for (int i = 0; i < keep; i++) tx.push_back(body[i]);
                end else if (pick < 87) begin
                    tx = {SYNC_HEAD, SYNC_TAIL, 8'hFF};
                    for (int i = 0; i < SLXD_BUFFER_DEPTH; i++) begin
                        tx.push_back(fill_byte(FILL_RAND));
                    end
                end else begin
                    // line noise, sync bytes likely; not counted toward the phase's bytes
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(3))
                            0:       tx.push_back(SYNC_HEAD);
                            1:       tx.push_back(SYNC_TAIL);
                            default: tx.push_back(fill_byte(FILL_RAND));
                        endcase
                    end
                    send_all();
                    continue;
                end
                counted += tx.size();
                send_all();
            end
        end
        push <= 1'b0;

        // drain, then give a stray item time to show up
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.fails == 0) begin
            $display("PASS sync_length_xor_frame_decoder_core");
        end else begin
            $display("FAIL sync_length_xor_frame_decoder_core");
        end
        $finish;
    end

endmodule
